// ===== sv/mbsd_pkg.sv =====
package mbsd_pkg;

    // Command codes: bits 6:4 of a channel status byte.
    localparam logic [2:0] CMD_NOTE_OFF  = 3'd0;
    localparam logic [2:0] CMD_NOTE_ON   = 3'd1;
    localparam logic [2:0] CMD_POLY_AT   = 3'd2;
    localparam logic [2:0] CMD_CTRL      = 3'd3;
    localparam logic [2:0] CMD_PROGRAM   = 3'd4;
    localparam logic [2:0] CMD_CHAN_AT   = 3'd5;
    localparam logic [2:0] CMD_BEND      = 3'd6;

    // Message kinds on the result stream.
    localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
    localparam logic [2:0] KIND_CTRL     = 3'd2;
    localparam logic [2:0] KIND_PROGRAM  = 3'd3;
    localparam logic [2:0] KIND_BEND     = 3'd4;

    // Byte class boundaries.
    localparam logic [7:0] RT_FIRST      = 8'hF8;
    localparam logic [7:0] SYS_FIRST     = 8'hF0;

    // Controller numbers with special meaning.
    localparam logic [6:0] CC_VOL_FIRST  = 7'd1;
    localparam logic [6:0] CC_VOL_LAST   = 7'd4;
    localparam logic [6:0] CC_EXPR_BEND  = 7'd11;

    localparam int QUEUE_DEPTH = 2;

    // One complete channel message handed from the parser to the decoder.
    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] channel;
        logic [6:0] d1;
        logic [6:0] d2;
    } t_msg;

    // Decoded result fields.
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [13:0] bend_value;
        logic        bend_active;
        logic [3:0]  volume_level;
    } t_result;

    // value * 15 / 127, truncated, by a reciprocal multiply with one correction step.
    function automatic logic [3:0] vol_scale(input logic [6:0] value);
        logic [10:0] v;
        logic [17:0] prod;
        logic [3:0]  q0;
        logic [10:0] rem;
        v    = {value, 4'b0000} - {4'b0000, value};
        prod = {7'd0, v} * 18'd129;
        q0   = prod[17:14];
        rem  = v - ({7'd0, q0} * 11'd127);
        if (rem >= 11'd127) begin
            vol_scale = q0 + 4'd1;
        end else begin
            vol_scale = q0;
        end
    endfunction

endpackage

// ===== sv/mbsd_front.sv =====
module mbsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    output logic                o_ready,
    output logic                o_push,
    output mbsd_pkg::t_msg      o_msg,
    input  logic                i_queue_ready
);
    import mbsd_pkg::*;

    logic [7:0] r_running_status, n_running_status;
    logic [6:0] r_held_d1, n_held_d1;
    logic [6:0] r_held_d2, n_held_d2;
    logic [1:0] r_data_count, n_data_count;
    logic [1:0] r_needed_count, n_needed_count;

    logic       accept;
    logic [1:0] cnt_inc;
    logic [2:0] cmd;

    // The parser stalls only when the queue cannot take another message.
    assign o_ready = i_queue_ready;
    assign accept  = i_valid && i_queue_ready;
    assign cnt_inc = r_data_count + 2'd1;
    assign cmd     = r_running_status[6:4];

    // Byte classification and message assembly.
    always_comb begin
        n_running_status = r_running_status;
        n_held_d1        = r_held_d1;
        n_held_d2        = r_held_d2;
        n_data_count     = r_data_count;
        n_needed_count   = r_needed_count;
        o_push           = 1'b0;
        o_msg.cmd        = cmd;
        o_msg.channel    = r_running_status[3:0];
        o_msg.d1         = r_held_d1;
        o_msg.d2         = r_held_d2;
        if (accept) begin
            if (i_byte >= RT_FIRST) begin
                // Realtime bytes leave everything alone.
            end else if (i_byte >= SYS_FIRST) begin
                n_running_status = '0;
                n_data_count     = '0;
                n_needed_count   = '0;
            end else if (i_byte[7]) begin
                n_running_status = i_byte;
                n_data_count     = '0;
                case (i_byte[6:4]) inside
                    CMD_NOTE_OFF, CMD_NOTE_ON, CMD_CTRL, CMD_BEND: n_needed_count = 2'd2;
                    CMD_PROGRAM:                                   n_needed_count = 2'd1;
                    default:                                       n_needed_count = 2'd0;
                endcase
            end else if (r_running_status != 8'd0) begin
                if (cnt_inc == 2'd1) begin
                    n_held_d1 = i_byte[6:0];
                end else if (cnt_inc == 2'd2) begin
                    n_held_d2 = i_byte[6:0];
                end
                o_msg.d1 = n_held_d1;
                o_msg.d2 = n_held_d2;
                if (cnt_inc >= r_needed_count) begin
                    n_data_count = '0;
                    // Aftertouch closes a message that yields nothing.
                    case (cmd) inside
                        CMD_NOTE_OFF, CMD_NOTE_ON, CMD_CTRL, CMD_PROGRAM, CMD_BEND:
                            o_push = 1'b1;
                        default:
                            o_push = 1'b0;
                    endcase
                end else begin
                    n_data_count = cnt_inc;
                end
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_status <= '0;
            r_held_d1        <= '0;
            r_held_d2        <= '0;
            r_data_count     <= '0;
            r_needed_count   <= '0;
        end else begin
            r_running_status <= n_running_status;
            r_held_d1        <= n_held_d1;
            r_held_d2        <= n_held_d2;
            r_data_count     <= n_data_count;
            r_needed_count   <= n_needed_count;
        end
    end

endmodule

// ===== sv/mbsd_queue.sv =====
module mbsd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mbsd_pkg::t_msg      i_msg,
    output logic                o_ready,
    input  logic                i_pop,
    output logic                o_valid,
    output mbsd_pkg::t_msg      o_msg
);
    import mbsd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_msg             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_msg   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Storage for queued messages.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_msg;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    // A push that the queue takes while not popping raises the count by one.
    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

// ===== sv/mbsd_back.sv =====
module mbsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  mbsd_pkg::t_msg      i_msg,
    output logic                o_pop,
    output logic                o_valid,
    output mbsd_pkg::t_result   o_result,
    input  logic                i_ready
);
    import mbsd_pkg::*;

    logic    r_valid;
    t_result r_result;
    t_result n_result;
    logic    load;

    // Take the next message whenever the output register is empty or being drained.
    assign load     = i_valid && (!r_valid || i_ready);
    assign o_pop    = load;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Field decode of one message.
    always_comb begin
        n_result.kind         = KIND_NOTE_OFF;
        n_result.channel      = i_msg.channel;
        n_result.first_data   = i_msg.d1;
        n_result.second_data  = i_msg.d2;
        n_result.bend_value   = '0;
        n_result.bend_active  = 1'b0;
        n_result.volume_level = '0;
        case (i_msg.cmd)
            CMD_NOTE_OFF: n_result.kind = KIND_NOTE_OFF;
            CMD_NOTE_ON: begin
                n_result.kind = (i_msg.d2 == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            end
            CMD_CTRL: begin
                n_result.kind = KIND_CTRL;
                if (i_msg.d1 >= CC_VOL_FIRST && i_msg.d1 <= CC_VOL_LAST) begin
                    n_result.volume_level = vol_scale(i_msg.d2);
                end else if (i_msg.d1 == CC_EXPR_BEND) begin
                    // (value - 64) * 128 is the value with its top bit flipped, shifted.
                    n_result.bend_value  = {~i_msg.d2[6], i_msg.d2[5:0], 7'd0};
                    n_result.bend_active = 1'b1;
                end
            end
            CMD_PROGRAM: n_result.kind = KIND_PROGRAM;
            CMD_BEND: begin
                n_result.kind        = KIND_BEND;
                // Subtracting 8192 from a 14-bit value flips its top bit.
                n_result.bend_value  = {~i_msg.d2[6], i_msg.d2[5:0], i_msg.d1};
                n_result.bend_active = 1'b1;
            end
            default: n_result.kind = KIND_NOTE_OFF;
        endcase
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= n_result;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // A bend value is only flagged for pitch bend and control change results.
    a_bend_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.bend_active) |->
            (r_result.kind == KIND_BEND || r_result.kind == KIND_CTRL))
        else $error("bend flagged on a wrong message kind");

    // A volume level only comes with a control change that has no bend.
    a_vol_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.volume_level != 4'd0) |->
            (r_result.kind == KIND_CTRL && !r_result.bend_active))
        else $error("volume level on a wrong message");

endmodule

// ===== sv/midi_byte_stream_message_decoder_core.sv =====
// A byte that completes a message passes the parser-to-queue and then the queue-to-output
// register before its result shows on the master side.
// Throughput: one byte per cycle; the two-entry message queue and the output register let
// the parser keep taking bytes while a result waits, and it stalls only when the queue is full.
// Reset (synchronous, active low) clears running status, data counts, the queue and output.
module midi_byte_stream_message_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] channel, [10:4] first_data, [17:11] second_data,
                                        // [31:18] bend_value, [35:32] volume_level, [39:36] zero
    output logic [3:0]  m_axis_tuser    // [2:0] msg_kind, [3] bend_active
);
    import mbsd_pkg::*;

    logic    front_push;
    t_msg    front_msg;
    logic    queue_ready;
    logic    queue_valid;
    t_msg    queue_msg;
    logic    back_pop;
    t_result result;

    // Byte parser with running status.
    mbsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_byte        (s_axis_tdata),
        .o_ready       (s_axis_tready),
        .o_push        (front_push),
        .o_msg         (front_msg),
        .i_queue_ready (queue_ready)
    );

    // Message queue between parser and decoder.
    mbsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_msg   (front_msg),
        .o_ready (queue_ready),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_msg   (queue_msg)
    );

    // Message decoder and output register.
    mbsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_msg    (queue_msg),
        .o_pop    (back_pop),
        .o_valid  (m_axis_tvalid),
        .o_result (result),
        .i_ready  (m_axis_tready)
    );

    // Pack the result onto the master side.
    assign m_axis_tdata = {4'd0, result.volume_level, result.bend_value, result.second_data,
                           result.first_data, result.channel};
    assign m_axis_tuser = {result.bend_active, result.kind};

endmodule

// ===== tb/midi_byte_stream_message_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module midi_byte_stream_message_decoder_core_tb;

    import mbsd_pkg::*;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          RANDOM_BYTES   = 750;
    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [7:0]  RT_LAST        = 8'hFF;
    localparam logic [7:0]  SYS_LAST       = 8'hF7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [3:0] channel, [10:4] first_data, [17:11] second_data,
                                        // [31:18] bend_value, [35:32] volume_level
    logic [3:0]  m_axis_tuser;          // [2:0] msg_kind, [3] bend_active

    // Shadow of the parser state.
    logic [7:0]  run_status = 8'd0;
    logic [6:0]  held_d1 = 7'd0;
    logic [6:0]  held_d2 = 7'd0;
    logic [1:0]  data_cnt = 2'd0;
    logic [1:0]  need_cnt = 2'd0;

    t_result     expected_msgs[$];
    int          parsed_bytes = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          quiet_mode = 1'b0;

    midi_byte_stream_message_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Track one byte through the running-status parser and build the decoded message.
    function automatic bit decode_midi_byte(input logic [7:0] rx, output t_result msg);
        msg = '0;
        if (rx >= RT_FIRST) begin
            return 1'b0;
        end
        if (rx[7]) begin
            parsed_bytes++;
            data_cnt = 2'd0;
            if (rx >= SYS_FIRST) begin
                run_status = 8'd0;
                need_cnt   = 2'd0;
                return 1'b0;
            end
            run_status = rx;
            case (rx[6:4])
                CMD_NOTE_OFF, CMD_NOTE_ON, CMD_CTRL, CMD_BEND: need_cnt = 2'd2;
                CMD_PROGRAM: need_cnt = 2'd1;
                default: need_cnt = 2'd0;
            endcase
            return 1'b0;
        end
        // Data with no running status is dropped.
        if (run_status == 8'd0) begin
            return 1'b0;
        end
        parsed_bytes++;
        data_cnt = data_cnt + 2'd1;
        if (data_cnt == 2'd1) begin
            held_d1 = rx[6:0];
        end else if (data_cnt == 2'd2) begin
            held_d2 = rx[6:0];
        end
        if (data_cnt < need_cnt) begin
            return 1'b0;
        end
        data_cnt = 2'd0;

        msg.channel     = run_status[3:0];
        msg.first_data  = held_d1;
        msg.second_data = held_d2;
        case (run_status[6:4])
            CMD_NOTE_OFF: msg.kind = KIND_NOTE_OFF;
            CMD_NOTE_ON: msg.kind = (held_d2 == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            CMD_CTRL: begin
                msg.kind = KIND_CTRL;
                if (held_d1 >= CC_VOL_FIRST && held_d1 <= CC_VOL_LAST) begin
                    msg.volume_level = 4'((int'(held_d2) * 15) / 127);
                end else if (held_d1 == CC_EXPR_BEND) begin
                    msg.bend_value  = 14'((int'(held_d2) - 64) * 128);
                    msg.bend_active = 1'b1;
                end
            end
            CMD_PROGRAM: msg.kind = KIND_PROGRAM;
            CMD_BEND: begin
                msg.kind        = KIND_BEND;
                msg.bend_value  = 14'(int'({held_d2, held_d1}) - 8192);
                msg.bend_active = 1'b1;
            end
            // Aftertouch closes a message that decodes to nothing.
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [7:0] status_byte(input logic [2:0] cmd, input logic [3:0] chan);
        return {1'b1, cmd, chan};
    endfunction

    // Data byte with a bias toward the extremes and the special controller numbers.
    function automatic logic [7:0] pick_data(input bit ctrl_number);
        int sel;
        sel = $urandom_range(0, 9);
        if (ctrl_number && sel < 3) begin
            return {1'b0, 7'($urandom_range(CC_VOL_FIRST, CC_VOL_LAST))};
        end else if (ctrl_number && sel == 3) begin
            return {1'b0, CC_EXPR_BEND};
        end else if (sel == 8) begin
            return 8'h00;
        end else if (sel == 9) begin
            return 8'h7F;
        end
        return 8'($urandom_range(0, 127));
    endfunction

    // Send one request and predict its result once the block takes it.
    task automatic push_byte(input logic [7:0] rx);
        t_result msg;
        while (!quiet_mode && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (decode_midi_byte(rx, msg)) begin
            expected_msgs.push_back(msg);
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_msgs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver side stalls at random except in quiet stretches.
    always @(posedge i_clk) begin
        m_axis_tready <= quiet_mode || ($urandom_range(0, 99) >= 11);
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_msgs.size() == 0) begin
                $error("unexpected result: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                want = expected_msgs.pop_front();
                if (m_axis_tuser[2:0] !== want.kind) begin
                    $error("msg_kind: expected %0d, got %0d", want.kind, m_axis_tuser[2:0]);
                    fail_count++;
                end
                if (m_axis_tdata[3:0] !== want.channel) begin
                    $error("channel: expected %0d, got %0d", want.channel, m_axis_tdata[3:0]);
                    fail_count++;
                end
                if (m_axis_tdata[10:4] !== want.first_data) begin
                    $error("first_data: expected %0d, got %0d",
                           want.first_data, m_axis_tdata[10:4]);
                    fail_count++;
                end
                if (m_axis_tdata[17:11] !== want.second_data) begin
                    $error("second_data: expected %0d, got %0d",
                           want.second_data, m_axis_tdata[17:11]);
                    fail_count++;
                end
                if (m_axis_tdata[31:18] !== want.bend_value) begin
                    $error("bend_value: expected %0d, got %0d",
                           $signed(want.bend_value), $signed(m_axis_tdata[31:18]));
                    fail_count++;
                end
                if (m_axis_tuser[3] !== want.bend_active) begin
                    $error("bend_active: expected %0d, got %0d",
                           want.bend_active, m_axis_tuser[3]);
                    fail_count++;
                end
                if (m_axis_tdata[35:32] !== want.volume_level) begin
                    $error("volume_level: expected %0d, got %0d",
                           want.volume_level, m_axis_tdata[35:32]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** midi_byte_stream_message_decoder_core: FAILED **");
            $finish;
        end
    end

    // Realtime bytes and data without running status leave no trace.
    task automatic test_ignored_bytes();
        push_byte(8'h45);
        push_byte(RT_FIRST);
        push_byte(RT_LAST);
    endtask

    // Note on, then note on with zero velocity under running status, with a
    // realtime byte in the middle of the second message.
    task automatic test_note_messages();
        push_byte(status_byte(CMD_NOTE_ON, 4'h0));
        push_byte(8'h3C);
        push_byte(8'h7F);
        push_byte(8'h40);
        push_byte(8'hFE);
        push_byte(8'h00);
    endtask

    // Volume controller at full scale, then the expression bend at its minimum.
    task automatic test_controllers();
        push_byte(status_byte(CMD_CTRL, 4'h4));
        push_byte({1'b0, CC_VOL_LAST});
        push_byte(8'h7F);
        push_byte({1'b0, CC_EXPR_BEND});
        push_byte(8'h00);
    endtask

    // Program change keeps the stale second byte; pitch bend at both ends.
    task automatic test_program_and_bend();
        push_byte(status_byte(CMD_PROGRAM, 4'hF));
        push_byte(8'h7F);
        push_byte(status_byte(CMD_BEND, 4'hF));
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h7F);
    endtask

    // Aftertouch gives nothing, a status mid-message drops the partial one,
    // and a system common byte clears running status.
    task automatic test_aftertouch_and_system();
        push_byte(status_byte(CMD_POLY_AT, 4'h2));
        push_byte(8'h11);
        push_byte(status_byte(CMD_CHAN_AT, 4'h3));
        push_byte(8'h22);
        push_byte(status_byte(CMD_NOTE_OFF, 4'hA));
        push_byte(8'h05);
        push_byte(status_byte(CMD_NOTE_ON, 4'h7));
        push_byte(8'h10);
        push_byte(8'h20);
        push_byte(SYS_LAST);
        push_byte(8'h05);
        push_byte(SYS_FIRST);
    endtask

    // A status byte, or none to reuse the running status, then one to four messages under running
    // status, with stray realtime bytes, noise and broken messages mixed in; or a system byte and data.
    task automatic send_random_phrase();
        int  sel;
        int  need;
        bit  broken;
        sel    = $urandom_range(0, 99);
        broken = 1'b0;
        if (sel < 5) begin
            push_byte(8'($urandom_range(SYS_FIRST, SYS_LAST)));
            repeat ($urandom_range(0, 2)) push_byte(pick_data(1'b0));
            return;
        end
        if (sel >= 10) begin
            push_byte(status_byte(3'($urandom_range(CMD_NOTE_OFF, CMD_BEND)),
                                  4'($urandom_range(0, 15))));
        end
        repeat ($urandom_range(1, 4)) begin
            need = (need_cnt == 2'd0) ? 1 : int'(need_cnt);
            for (int pos = 0; pos < need && !broken; pos++) begin
                if ($urandom_range(0, 99) < 4) begin
                    push_byte(8'($urandom_range(RT_FIRST, RT_LAST)));
                end
                if ($urandom_range(0, 99) < 3) begin
                    broken = 1'b1;
                end else if ($urandom_range(0, 99) < 3) begin
                    push_byte(8'($urandom_range(0, 255)));
                end else begin
                    push_byte(pick_data(run_status[6:4] == CMD_CTRL && pos == 0));
                end
            end
        end
    endtask

    // The sender holds off until the output side has caught up.
    task automatic test_sender_pause();
        repeat (3) send_random_phrase();
        wait_for_results();
        repeat (2) send_random_phrase();
    endtask

    task automatic test_random_streams();
        int start;
        start = parsed_bytes;
        while (parsed_bytes - start < RANDOM_BYTES) begin
            quiet_mode = (parsed_bytes - start >= 250) && (parsed_bytes - start < 400);
            send_random_phrase();
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ignored_bytes();
        test_note_messages();
        test_controllers();
        test_program_and_bend();
        test_aftertouch_and_system();
        test_sender_pause();
        test_random_streams();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_msgs.size() == 0) begin
            $display("** midi_byte_stream_message_decoder_core: PASSED **");
        end else begin
            $display("** midi_byte_stream_message_decoder_core: FAILED **");
        end
        $finish;
    end

endmodule
